// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define MTNP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtnp port check failed");

// same-cycle implication
`define MTNP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `MTNP_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/mtnp_pkg.sv =====
package mtnp_pkg;

  localparam int NOTE_COUNT      = 128;
  localparam int DEF_STACK_DEPTH = 4;

  localparam int BYTE_W = 8;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int TICK_W = 32;

  localparam int OUT_FIELDS_W = NOTE_W + VEL_W + 2 * TICK_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // status byte codes
  localparam logic [3:0] ST_NOTE_OFF_HI = 4'h8;
  localparam logic [3:0] ST_NOTE_ON_HI  = 4'h9;
  localparam logic [3:0] ST_PROGRAM_HI  = 4'hC;
  localparam logic [3:0] ST_PRESSURE_HI = 4'hD;
  localparam logic [7:0] ST_META        = 8'hFF;

  // result kinds
  localparam logic KIND_NOTE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_STATUS    = 3'd1,
    PH_DATA1     = 3'd2,
    PH_DATA2     = 3'd3,
    PH_META_TYPE = 3'd4,
    PH_META_LEN  = 3'd5,
    PH_SKIP      = 3'd6
  } phase_e;

  // note request from the parser to the stack
  typedef struct packed {
    logic              valid;
    logic              on;
    logic              clr;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [TICK_W-1:0] tick;
  } note_op_t;

  typedef struct packed {
    logic              kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [TICK_W-1:0] on_tick;
    logic [TICK_W-1:0] off_tick;
  } result_t;

endpackage

// ===== rtl/mtnp_parser.sv =====
module mtnp_parser
  import mtnp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              last_i,
  output note_op_t          op_o
);

  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   delta_q, delta_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [BYTE_W-1:0]   status_q, status_d;
  logic [NOTE_W-1:0]   first_q, first_d;
  logic [TICK_W-1:0]   skip_q, skip_d;

  always_comb begin
    logic [TICK_W-1:0] acc;
    logic [BYTE_W-1:0] st;
    logic              is_data;
    logic [1:0]        cnt;
    phase_d  = phase_q;
    delta_d  = delta_q;
    tick_d   = tick_q;
    status_d = status_q;
    first_d  = first_q;
    skip_d   = skip_q;
    acc      = '0;
    st       = status_q;
    is_data  = 1'b0;
    cnt      = 2'd0;
    if (accept_i) begin
      unique case (phase_q)
        PH_DELTA: begin
          acc = {delta_q[TICK_W-8:0], byte_i[6:0]};
          if (!byte_i[7]) begin
            tick_d  = tick_q + acc;
            delta_d = '0;
            phase_d = PH_STATUS;
          end else begin
            delta_d = acc;
          end
        end
        PH_STATUS: begin
          // a data byte here reuses the running status
          if (!byte_i[7]) begin
            st      = status_q;
            is_data = 1'b1;
          end else begin
            st       = byte_i;
            status_d = byte_i;
          end
          if (st[7:4] == ST_NOTE_ON_HI || st[7:4] == ST_NOTE_OFF_HI) begin
            if (is_data) begin
              first_d = byte_i[6:0];
              phase_d = PH_DATA2;
            end else begin
              phase_d = PH_DATA1;
            end
          end else if (st == ST_META) begin
            if (is_data) begin
              skip_d  = '0;
              phase_d = PH_META_LEN;
            end else begin
              phase_d = PH_META_TYPE;
            end
          end else begin
            cnt = (st[7:4] == ST_PROGRAM_HI || st[7:4] == ST_PRESSURE_HI) ? 2'd1 : 2'd2;
            cnt = cnt - {1'b0, is_data};
            skip_d  = TICK_W'(cnt);
            phase_d = (cnt != 2'd0) ? PH_SKIP : PH_DELTA;
          end
        end
        PH_DATA1: begin
          first_d = byte_i[6:0];
          phase_d = PH_DATA2;
        end
        PH_DATA2: begin
          phase_d = PH_DELTA;
        end
        PH_META_TYPE: begin
          skip_d  = '0;
          phase_d = PH_META_LEN;
        end
        PH_META_LEN: begin
          acc    = {skip_q[TICK_W-8:0], byte_i[6:0]};
          skip_d = acc;
          if (!byte_i[7]) begin
            phase_d = (acc != '0) ? PH_SKIP : PH_DELTA;
          end
        end
        PH_SKIP: begin
          acc    = (skip_q != '0) ? skip_q - TICK_W'(1) : skip_q;
          skip_d = acc;
          if (acc == '0) begin
            phase_d = PH_DELTA;
          end
        end
        default: begin
          phase_d = PH_DELTA;
        end
      endcase
      if (last_i) begin
        phase_d  = PH_DELTA;
        delta_d  = '0;
        tick_d   = '0;
        status_d = '0;
        first_d  = '0;
        skip_d   = '0;
      end
    end
  end

  // note request goes out on the second data byte of a note message
  always_comb begin
    op_o       = '0;
    op_o.valid = accept_i && (phase_q == PH_DATA2);
    op_o.on    = (status_q[7:4] == ST_NOTE_ON_HI) && (byte_i[6:0] != '0);
    op_o.clr   = last_i;
    op_o.note  = first_q;
    op_o.vel   = byte_i[6:0];
    op_o.tick  = tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      delta_q  <= '0;
      tick_q   <= '0;
      status_q <= '0;
      first_q  <= '0;
      skip_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      delta_q  <= delta_d;
      tick_q   <= tick_d;
      status_q <= status_d;
      first_q  <= first_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// ===== rtl/mtnp_stack.sv =====
module mtnp_stack
  import mtnp_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  note_op_t op_i,
  input  logic     clear_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output result_t  res_o
);

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(NOTE_COUNT * STACK_DEPTH);
  localparam int ENT_W  = VEL_W + TICK_W;

  logic [FILL_W-1:0] fill_mem [NOTE_COUNT];
  logic [ENT_W-1:0]  stk_mem [NOTE_COUNT * STACK_DEPTH];
  // an entry of fill_mem reads as zero until written since the last clear
  logic [NOTE_COUNT-1:0] fill_ok_q;

  logic              s1_valid_q;
  note_op_t          s1_op_q;
  logic [FILL_W-1:0] fill_rd_q;
  logic              fill_hit_q;

  logic              s2_valid_q;
  logic              s2_kind_q;
  logic [NOTE_W-1:0] s2_note_q;
  logic [VEL_W-1:0]  s2_vel_q;
  logic [TICK_W-1:0] s2_tick_q;
  logic [ENT_W-1:0]  stk_rd_q;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_new;
  logic              full, push, drop, pop, fill_we;
  logic [ADDR_W-1:0] base, wr_addr, rd_addr;

  // fill read on the accept edge
  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      fill_rd_q  <= fill_mem[op_i.note];
      fill_hit_q <= fill_ok_q[op_i.note];
      s1_op_q    <= op_i;
    end
  end

  always_comb begin
    fill     = fill_hit_q ? fill_rd_q : '0;
    full     = fill >= FILL_W'(STACK_DEPTH);
    push     = s1_op_q.on && !full;
    drop     = s1_op_q.on && full;
    pop      = !s1_op_q.on && (fill != '0);
    fill_new = push ? fill + FILL_W'(1) : fill - FILL_W'(1);
    fill_we  = s1_valid_q && (push || pop);
    base     = ADDR_W'(s1_op_q.note) * ADDR_W'(STACK_DEPTH);
    wr_addr  = base + ADDR_W'(fill);
    rd_addr  = base + ADDR_W'(fill_new);
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[s1_op_q.note] <= fill_new;
    end
    if (s1_valid_q && push) begin
      stk_mem[wr_addr] <= {s1_op_q.vel, s1_op_q.tick};
    end
    if (s1_valid_q && pop) begin
      stk_rd_q <= stk_mem[rd_addr];
    end
    s2_kind_q <= drop ? KIND_DROP : KIND_NOTE;
    s2_note_q <= s1_op_q.note;
    s2_vel_q  <= s1_op_q.vel;
    s2_tick_q <= s1_op_q.tick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_ok_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= op_i.valid;
      s2_valid_q <= s1_valid_q && (drop || pop);
      // the last byte of a track drops every fill, its own update included
      if (clear_i) begin
        fill_ok_q <= '0;
      end else if (fill_we && !s1_op_q.clr) begin
        fill_ok_q[s1_op_q.note] <= 1'b1;
      end
    end
  end

  always_comb begin
    res_o.kind     = s2_kind_q;
    res_o.note     = s2_note_q;
    res_o.vel      = (s2_kind_q == KIND_DROP) ? s2_vel_q : stk_rd_q[ENT_W-1:TICK_W];
    res_o.on_tick  = (s2_kind_q == KIND_DROP) ? s2_tick_q : stk_rd_q[TICK_W-1:0];
    res_o.off_tick = s2_tick_q;
  end

  assign res_valid_o = s2_valid_q;
  assign busy_o      = s1_valid_q || s2_valid_q;

endmodule

// ===== rtl/mtnp_res_fifo.sv =====
module mtnp_res_fifo
  import mtnp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    full_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/midi_track_note_pairer_unit.sv =====
// channel   dir  tdata                                  tlast      tuser
// s_axis    in   data_byte[7:0]                         last_byte  -
// m_axis    out  note, velocity, start tick, end tick   -          kind
//
// one byte per cycle while the stack is not busy and the output queue is not full;
// a note's second data byte stalls input over fill read, push or pop, any result.
// results wait in a 2-entry output queue, so input keeps flowing while one waits.
// reset is asynchronous and leaves every note stack empty at once; no memory sweep.
// the last byte of a track clears the parser and all stacks in the same transfer.
module midi_track_note_pairer_unit
  import mtnp_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // data_byte
  input  logic                   s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // note_number, note_velocity, note-on tick, note-off tick, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser    // kind
);

  logic     accept;
  logic     busy;
  logic     fifo_full;
  logic     res_valid;
  note_op_t op;
  result_t  res;
  result_t  out_res;

  assign s_axis_tready = !busy && !fifo_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mtnp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .op_o     (op)
  );

  mtnp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .clear_i     (accept && s_axis_tlast),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtnp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res),
    .full_o  (fifo_full)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_res.off_tick,
                         out_res.on_tick, out_res.vel, out_res.note};

endmodule

// ===== rtl/mtnp_checker.sv =====
`include "assert_macros.svh"

module mtnp_checker
  import mtnp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  localparam int START_LO = NOTE_W + VEL_W;
  localparam int END_LO   = START_LO + TICK_W;

  logic                 out_stall;
  logic                 in_xfer;
  logic                 drop_out;
  logic [OUT_TDATA_W:0] out_word;
  logic [TICK_W-1:0]    on_tick;
  logic [TICK_W-1:0]    off_tick;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign drop_out  = m_axis_tvalid && (m_axis_tuser == KIND_DROP);
  assign out_word  = {m_axis_tuser, m_axis_tdata};
  assign on_tick   = m_axis_tdata[START_LO +: TICK_W];
  assign off_tick  = m_axis_tdata[END_LO +: TICK_W];

  `MTNP_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid)
  `MTNP_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(out_word))
  `MTNP_ASSERT_IMPL(a_drop_ticks, clk_i, rst_ni, drop_out, off_tick == on_tick)
  // a result follows its transfer through the stack and the queue
  `MTNP_ASSERT_IMPL(a_result_origin, clk_i, rst_ni, $rose(m_axis_tvalid), $past(in_xfer, 3))

endmodule

bind midi_track_note_pairer_unit mtnp_checker u_mtnp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
